@@ rtl/twm_pkg.sv @@
// ----------------------------------------------------------------------------
// twm_pkg: shared types and constants for the two-list wakeup merge
// Entry layout, request/response payloads, opcodes and list control structs.
// ----------------------------------------------------------------------------
package twm_pkg;

  localparam int LIST_DEPTH = 16;
  localparam int POS_W      = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam int CNT_W      = $clog2(LIST_DEPTH + 1);
  localparam int SLOT_W     = 4;
  localparam int CFG_W      = 5;
  localparam int CFG_IDX_W  = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_CURRENT_COUNT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_NEXT_COUNT    = 1'b1;

  typedef enum logic [1:0] {
    OP_WRITE_CUR  = 2'd0,
    OP_WRITE_NEXT = 2'd1,
    OP_FETCH      = 2'd2,
    OP_REWIND     = 2'd3
  } opcode_t;

  typedef struct packed {
    logic [31:0] stream_id;
    logic [31:0] wakeup_time;
    logic [1:0]  kind;
  } entry_t;

  typedef struct packed {
    opcode_t           opcode;
    logic [SLOT_W-1:0] entry_slot;
    logic [31:0]       entry_stream_id;
    logic [31:0]       entry_wakeup_time;
    logic [1:0]        entry_kind;
  } req_t;

  typedef struct packed {
    logic        result_valid;
    logic        from_next_list;
    logic [31:0] out_stream_id;
    logic [31:0] out_wakeup_time;
    logic [1:0]  out_kind;
    logic        all_used;
  } rsp_t;

  typedef struct packed {
    logic             wr_en;
    logic [POS_W-1:0] wr_slot;
    entry_t           wr_entry;
    logic             cfg_wr;
    logic [CFG_W-1:0] cfg_count;
    logic             rewind;
    logic             advance;
  } list_ctl_t;

  typedef struct packed {
    entry_t entry;
    logic   empty;
    logic   ended;
    logic   ended_next;
  } list_stat_t;

endpackage

@@ rtl/twm_list.sv @@
// ----------------------------------------------------------------------------
// twm_list: one cyclic wakeup list
// Entry table, count, read position and end flag with rewind and advance.
// ----------------------------------------------------------------------------
module twm_list (
  input  logic                   clk,
  input  logic                   rst,
  input  twm_pkg::list_ctl_t     ctl,
  output twm_pkg::list_stat_t    stat
);

  twm_pkg::entry_t                 tab [twm_pkg::LIST_DEPTH];
  logic [twm_pkg::CNT_W-1:0]       count, count_next;
  logic [twm_pkg::POS_W-1:0]       pos, pos_next;
  logic                            ended, ended_next;

  logic [twm_pkg::POS_W-1:0]       pos_base, pos_adv;
  logic                            ended_base;
  logic [twm_pkg::CNT_W-1:0]       pos_inc;
  logic [twm_pkg::CNT_W-1:0]       cfg_sat;

  always_comb begin
    pos_base   = ctl.rewind ? '0 : pos;
    ended_base = ctl.rewind ? 1'b0 : ended;
    pos_inc    = twm_pkg::CNT_W'(pos_base) + twm_pkg::CNT_W'(1);
    pos_adv    = (pos_inc >= count) ? '0 : pos_inc[twm_pkg::POS_W-1:0];
    cfg_sat    = (twm_pkg::CNT_W'(ctl.cfg_count) > twm_pkg::CNT_W'(twm_pkg::LIST_DEPTH))
                 ? twm_pkg::CNT_W'(twm_pkg::LIST_DEPTH) : twm_pkg::CNT_W'(ctl.cfg_count);

    count_next = count;
    pos_next   = pos_base;
    ended_next = ended_base;
    if (ctl.cfg_wr) begin
      // count write rewinds the index but keeps the end flag
      count_next = cfg_sat;
      pos_next   = '0;
      ended_next = ended;
    end else if (ctl.advance) begin
      pos_next   = pos_adv;
      ended_next = (pos_adv == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      pos   <= '0;
      ended <= 1'b0;
    end else begin
      count <= count_next;
      pos   <= pos_next;
      ended <= ended_next;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      tab[ctl.wr_slot] <= ctl.wr_entry;
    end
  end

  always_comb begin
    stat.entry      = tab[pos_base];
    stat.empty      = (count == '0);
    stat.ended      = ended;
    stat.ended_next = ended_next;
  end

endmodule

@@ rtl/two_list_wakeup_merge.sv @@
// Flow: a request is registered in s1 at acceptance; its response is loaded into rsp
//   when s1 fires. The per-request list update is one pass.
// Throughput: one request per cycle while rsp is not stalled by rsp_ready.
// Reset: rst (synchronous, active high) clears handshake state, counts,
//   positions and end flags; entry tables stay undefined until written.
// ----------------------------------------------------------------------------
// two_list_wakeup_merge: merge of a current and a next wakeup list
// Loads entries, hands out the earlier list head (ties: current; current ended: next), rewinds.
// ----------------------------------------------------------------------------
module two_list_wakeup_merge (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            req_valid,
  output logic                            req_ready,
  input  twm_pkg::req_t                   req,
  output logic                            rsp_valid,
  input  logic                            rsp_ready,
  output twm_pkg::rsp_t                   rsp,
  input  logic                            cfg_we,
  input  logic [twm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [twm_pkg::CFG_W-1:0]       cfg_data
);

  logic                 s1_valid;
  twm_pkg::req_t        s1;
  logic                 fire;

  twm_pkg::list_ctl_t   cur_ctl, nxt_ctl;
  twm_pkg::list_stat_t  cur_st, nxt_st;

  logic                 is_fetch, both_empty, both_ended, take, rewind;
  logic                 cur_ended_eff, src, slot_ok;
  twm_pkg::entry_t      pick;
  twm_pkg::rsp_t        rsp_next;

  assign fire      = s1_valid && (!rsp_valid || rsp_ready);
  assign req_ready = !s1_valid || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (req_ready) begin
      s1_valid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && req_ready) begin
      s1 <= req;
    end
  end

  always_comb begin
    is_fetch   = (s1.opcode == twm_pkg::OP_FETCH);
    both_empty = cur_st.empty && nxt_st.empty;
    both_ended = cur_st.ended && nxt_st.ended;
    take       = fire && is_fetch && !both_empty;
    // both lists ended: rewind both before choosing
    rewind     = fire && ((s1.opcode == twm_pkg::OP_REWIND) || (take && both_ended));
    cur_ended_eff = cur_st.ended && !both_ended;
    slot_ok    = (({1'b0, s1.entry_slot}) < (twm_pkg::SLOT_W + 1)'(twm_pkg::LIST_DEPTH));

    if (cur_st.empty) begin
      src = 1'b1;
    end else if (nxt_st.empty) begin
      src = 1'b0;
    end else if (cur_ended_eff) begin
      src = 1'b1;
    end else begin
      src = !(cur_st.entry.wakeup_time <= nxt_st.entry.wakeup_time);
    end

    cur_ctl.wr_en            = fire && (s1.opcode == twm_pkg::OP_WRITE_CUR) && slot_ok;
    cur_ctl.wr_slot          = s1.entry_slot[twm_pkg::POS_W-1:0];
    cur_ctl.wr_entry.stream_id   = s1.entry_stream_id;
    cur_ctl.wr_entry.wakeup_time = s1.entry_wakeup_time;
    cur_ctl.wr_entry.kind        = s1.entry_kind;
    cur_ctl.cfg_wr           = cfg_we && (cfg_index == twm_pkg::CFG_CURRENT_COUNT);
    cur_ctl.cfg_count        = cfg_data;
    cur_ctl.rewind           = rewind;
    cur_ctl.advance          = take && !src;

    nxt_ctl                  = cur_ctl;
    nxt_ctl.wr_en            = fire && (s1.opcode == twm_pkg::OP_WRITE_NEXT) && slot_ok;
    nxt_ctl.cfg_wr           = cfg_we && (cfg_index == twm_pkg::CFG_NEXT_COUNT);
    nxt_ctl.advance          = take && src;

    pick = take ? (src ? nxt_st.entry : cur_st.entry) : '0;

    rsp_next.result_valid    = take;
    rsp_next.from_next_list  = take && src;
    rsp_next.out_stream_id   = pick.stream_id;
    rsp_next.out_wakeup_time = pick.wakeup_time;
    rsp_next.out_kind        = pick.kind;
    rsp_next.all_used        = (cur_st.ended_next && nxt_st.ended_next) ||
                               (cur_st.ended_next && nxt_st.empty) ||
                               (cur_st.empty && nxt_st.ended_next);
  end

  twm_list u_cur (
    .clk  (clk),
    .rst  (rst),
    .ctl  (cur_ctl),
    .stat (cur_st)
  );

  twm_list u_nxt (
    .clk  (clk),
    .rst  (rst),
    .ctl  (nxt_ctl),
    .stat (nxt_st)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (fire) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      rsp <= rsp_next;
    end
  end

`ifndef NO_ASSERTIONS
  // a processed request always lands in the response register
  a_fire_loads_rsp: assert property (@(posedge clk) disable iff (rst)
    fire |=> rsp_valid)
    else $error("processed request did not produce a response");

  // a held request is not dropped from the input register
  a_s1_holds: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !fire) |=> s1_valid)
    else $error("stalled request lost");

  // a response without an entry carries zero payload
  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp.result_valid) |->
      (!rsp.from_next_list && rsp.out_stream_id == '0 &&
       rsp.out_wakeup_time == '0 && rsp.out_kind == '0))
    else $error("invalid response with nonzero entry");

  // only one list advances per request
  a_one_advance: assert property (@(posedge clk) disable iff (rst)
    !(cur_ctl.advance && nxt_ctl.advance))
    else $error("both lists advanced");
`endif

endmodule
